// ===== hw/rtl/ftsp_pkg.sv =====
// shared types and constants of the face tracking servo pointer
package ftsp_pkg;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_ENABLE  = 3'd0;
	localparam logic [2:0] REG_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_STEP    = 3'd2;
	localparam logic [2:0] REG_BODYMAX = 3'd3;
	localparam logic [2:0] REG_HEADMAX = 3'd4;

	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	localparam logic        ENABLE_RST  = 1'b1;
	localparam logic [9:0]  TIMEOUT_RST = 10'd60;
	localparam logic [3:0]  STEP_RST    = 4'd2;
	localparam logic [6:0]  BODYMAX_RST = 7'd45;
	localparam logic [6:0]  HEADMAX_RST = 7'd15;

	localparam logic [10:0] TICKS_SAT  = 11'h7FF;
	localparam logic [6:0]  LIMIT_CAP  = 7'd90;
	localparam logic [7:0]  ANGLE_MID  = 8'd90;
	localparam logic [8:0]  STORED_X_RST = 9'd160;
	localparam logic [7:0]  STORED_Y_RST = 8'd120;

	typedef struct packed {
		logic       action;
		logic       face_present;
		logic [8:0] face_x;
		logic [7:0] face_y;
	} req_word_t;

	typedef struct packed {
		logic [7:0] body_angle;
		logic [7:0] head_angle;
	} rsp_word_t;

endpackage

// ===== hw/rtl/face_tracking_servo_pointer_core.sv =====
// face tracking servo pointer: report/tick handling, proportional aim and return to centre
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  req     | in        | req_valid/req_ready | action, face_present, face_x, face_y
//  rsp     | out       | rsp_valid/rsp_ready | body_angle, head_angle (ticks only)
//  apb     | in        | psel/penable/pready | five config registers at 4*index
//
//  one word per cycle: a word sits in the input register, where the
//  aim path (one multiplier per axis, divide by the image half folded into a
//  reciprocal gain taken at config write) settles before the result register
//  a tick that moves the servos is held in the input register only while the
//  result register is full and rsp_ready is low; reports and quiet ticks never stall
//  reset (arst_n low) clears the pipeline, loads the register defaults and centres
//  the offsets with the tick count saturated
module face_tracking_servo_pointer_core #(
	parameter int IMAGE_WIDTH  = 320,
	parameter int IMAGE_HEIGHT = 240
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  ftsp_pkg::req_word_t            req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output ftsp_pkg::rsp_word_t            rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ftsp_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	// image centre and exact reciprocal: floor(p/c) == (p*M) >> K for p < 90*c
	localparam int CX = IMAGE_WIDTH / 2;
	localparam int CY = IMAGE_HEIGHT / 2;
	localparam int KX = $clog2(CX * CX * 90);
	localparam int KY = $clog2(CY * CY * 90);
	localparam longint unsigned MX = ((64'd1 << KX) + CX - 1) / CX;
	localparam longint unsigned MY = ((64'd1 << KY) + CY - 1) / CY;
	localparam int MULWX = $clog2(90 * MX + 1);
	localparam int MULWY = $clog2(90 * MY + 1);
	// distance from centre, wide enough for centre and any 9 or 8 bit position
	localparam int DWX = $clog2(((CX > 511) ? CX : 511) + 1);
	localparam int DWY = $clog2(((CY > 255) ? CY : 255) + 1);
	localparam int PRWX = DWX + MULWX;
	localparam int PRWY = DWY + MULWY;

	// config registers
	logic             enable_q;
	logic [9:0]       timeout_q;
	logic [3:0]       step_q;
	logic [6:0]       body_span_q;
	logic [6:0]       head_span_q;
	logic [6:0]       body_lim_q;   // min(body_span, 90)
	logic [6:0]       head_lim_q;
	logic [MULWX-1:0] body_mul_q;   // body_lim * reciprocal of cx
	logic [MULWY-1:0] head_mul_q;

	// tracking state
	logic              face_seen_q;
	logic [8:0]        stored_x_q;
	logic [7:0]        stored_y_q;
	logic [10:0]       ticks_q;
	logic signed [7:0] body_off_q;
	logic signed [7:0] head_off_q;

	// input register and result register
	logic                valid_s1;
	ftsp_pkg::req_word_t req_s1;
	logic                rsp_valid_q;
	ftsp_pkg::rsp_word_t rsp_q;

	logic cfg_wr;
	logic fire_s1;
	logic adv_s1;
	logic tick_s1;
	logic emit_s1;
	logic track;
	logic back;
	logic timed_out;
	logic [10:0] ticks_inc;

	logic [DWX-1:0]    pos_x;
	logic [DWX-1:0]    dist_x;
	logic              neg_x;
	logic [PRWX-1:0]   prod_x;
	logic [6:0]        mag_x;
	logic signed [7:0] body_aim;
	logic [DWY-1:0]    pos_y;
	logic [DWY-1:0]    dist_y;
	logic              neg_y;
	logic [PRWY-1:0]   prod_y;
	logic [6:0]        mag_y;
	logic signed [7:0] head_aim;
	logic signed [7:0] body_nx;
	logic signed [7:0] head_nx;

	function automatic logic [6:0] cap_limit(input logic [6:0] m);
		return (m > ftsp_pkg::LIMIT_CAP) ? ftsp_pkg::LIMIT_CAP : m;
	endfunction

	// step toward zero, landing on zero when within one step
	function automatic logic signed [7:0] toward_zero(input logic signed [7:0] v,
			input logic [3:0] s);
		logic signed [7:0] ss;
		ss = $signed({4'b0000, s});
		if (v > ss) begin
			return v - ss;
		end else if (v < -ss) begin
			return v + ss;
		end
		return 8'sd0;
	endfunction

	// apb: no wait states, writes land on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[ftsp_pkg::ADDR_W-1:2])
			ftsp_pkg::REG_ENABLE:  prdata = {31'd0, enable_q};
			ftsp_pkg::REG_TIMEOUT: prdata = {22'd0, timeout_q};
			ftsp_pkg::REG_STEP:    prdata = {28'd0, step_q};
			ftsp_pkg::REG_BODYMAX: prdata = {25'd0, body_span_q};
			ftsp_pkg::REG_HEADMAX: prdata = {25'd0, head_span_q};
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ftsp_pkg::ENABLE_RST;
			timeout_q   <= ftsp_pkg::TIMEOUT_RST;
			step_q      <= ftsp_pkg::STEP_RST;
			body_span_q <= ftsp_pkg::BODYMAX_RST;
			head_span_q <= ftsp_pkg::HEADMAX_RST;
			body_lim_q  <= ftsp_pkg::BODYMAX_RST;
			head_lim_q  <= ftsp_pkg::HEADMAX_RST;
			body_mul_q  <= MULWX'(MX) * MULWX'(ftsp_pkg::BODYMAX_RST);
			head_mul_q  <= MULWY'(MY) * MULWY'(ftsp_pkg::HEADMAX_RST);
		end else if (cfg_wr) begin
			unique case (paddr[ftsp_pkg::ADDR_W-1:2])
				ftsp_pkg::REG_ENABLE:  enable_q  <= pwdata[0];
				ftsp_pkg::REG_TIMEOUT: timeout_q <= pwdata[9:0];
				ftsp_pkg::REG_STEP:    step_q    <= pwdata[3:0];
				ftsp_pkg::REG_BODYMAX: begin
					body_span_q <= pwdata[6:0];
					body_lim_q  <= cap_limit(pwdata[6:0]);
					body_mul_q  <= MULWX'(MX) * MULWX'(cap_limit(pwdata[6:0]));
				end
				ftsp_pkg::REG_HEADMAX: begin
					head_span_q <= pwdata[6:0];
					head_lim_q  <= cap_limit(pwdata[6:0]);
					head_mul_q  <= MULWY'(MY) * MULWY'(cap_limit(pwdata[6:0]));
				end
				default: ;
			endcase
		end
	end

	// word in the input register is decided here against the current state
	always_comb begin
		tick_s1   = (req_s1.action == ftsp_pkg::ACT_TICK);
		ticks_inc = (ticks_q == ftsp_pkg::TICKS_SAT) ? ticks_q : ticks_q + 11'd1;
		timed_out = (ticks_inc > {1'b0, timeout_q});
		track     = face_seen_q;
		back      = !face_seen_q && timed_out && (body_off_q != 8'sd0 || head_off_q != 8'sd0);
		emit_s1   = valid_s1 && enable_q && tick_s1 && (track || back);

		// body aim: sign from side of centre, magnitude clamps once past the edge
		pos_x    = DWX'(stored_x_q);
		neg_x    = (pos_x > DWX'(CX));
		dist_x   = neg_x ? (pos_x - DWX'(CX)) : (DWX'(CX) - pos_x);
		prod_x   = PRWX'(dist_x) * PRWX'(body_mul_q);
		mag_x    = (dist_x >= DWX'(CX)) ? body_lim_q : 7'(prod_x >> KX);
		body_aim = neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});

		// head aim, same scheme on rows
		pos_y    = DWY'(stored_y_q);
		neg_y    = (pos_y > DWY'(CY));
		dist_y   = neg_y ? (pos_y - DWY'(CY)) : (DWY'(CY) - pos_y);
		prod_y   = PRWY'(dist_y) * PRWY'(head_mul_q);
		mag_y    = (dist_y >= DWY'(CY)) ? head_lim_q : 7'(prod_y >> KY);
		head_aim = neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});

		body_nx = track ? body_aim : toward_zero(body_off_q, step_q);
		head_nx = track ? head_aim : toward_zero(head_off_q, step_q);
	end

	// only a moving tick needs the result register
	assign adv_s1    = !emit_s1 || !rsp_valid_q || rsp_ready;
	assign fire_s1   = valid_s1 && adv_s1;
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			face_seen_q <= 1'b0;
			stored_x_q  <= ftsp_pkg::STORED_X_RST;
			stored_y_q  <= ftsp_pkg::STORED_Y_RST;
			ticks_q     <= ftsp_pkg::TICKS_SAT;
			body_off_q  <= 8'sd0;
			head_off_q  <= 8'sd0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			// retire the result word or refill it from a moving tick
			if (fire_s1 && emit_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			// disabled: word is dropped and state stays put
			if (fire_s1 && enable_q) begin
				if (!tick_s1) begin
					face_seen_q <= req_s1.face_present;
					ticks_q     <= '0;
					if (req_s1.face_present) begin
						stored_x_q <= req_s1.face_x;
						stored_y_q <= req_s1.face_y;
					end
				end else begin
					ticks_q     <= ticks_inc;
					face_seen_q <= 1'b0;
					if (track || back) begin
						body_off_q <= body_nx;
						head_off_q <= head_nx;
					end
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (req_ready) begin
			req_s1 <= req;
		end
		if (fire_s1 && emit_s1) begin
			rsp_q.body_angle <= 8'(ftsp_pkg::ANGLE_MID + $unsigned(body_nx));
			rsp_q.head_angle <= 8'(ftsp_pkg::ANGLE_MID + $unsigned(head_nx));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// offsets never leave the servo range
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(body_off_q >= -8'sd90) && (body_off_q <= 8'sd90) &&
		(head_off_q >= -8'sd90) && (head_off_q <= 8'sd90))
		else $error("offset outside servo range");

	// a delivered word always carries angles within 0..180
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.body_angle <= 8'd180) && (rsp.head_angle <= 8'd180))
		else $error("servo angle out of range");

	// input stalls only behind a full, unaccepted result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && rsp_valid && !rsp_ready)
		else $error("input stalled without a blocked result");

	// a processed report restarts the tick count
	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && enable_q && !tick_s1) |=> (ticks_q == 11'd0))
		else $error("report did not restart tick count");

	// disabled words never produce a result
	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !enable_q) |-> !emit_s1)
		else $error("result while tracking disabled");

endmodule
